FILE: rtl/svmgu_pkg.sv
// Shared types, constants and arithmetic helpers of the SVM gradient store.
`default_nettype none

package svmgu_pkg;

  localparam int unsigned NUM_POINTS = 1024;
  localparam int unsigned ADDR_W     = $clog2(NUM_POINTS);
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DEC_W      = 64;
  // room for a word plus two rounded Q16.16 products
  localparam int unsigned ACC_W      = 50;
  localparam int unsigned MUL_W      = DATA_W + 1;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [DEC_W-1:0]  dec_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam dec_t  DEC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam dec_t  DEC_MIN  = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_ALPHA = 2'd0,
    OP_ACCUM      = 2'd1,
    OP_PAIR       = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  typedef struct packed {
    logic  rd_en;
    addr_t g_raddr;
    addr_t a_raddr_first;
    addr_t a_raddr_second;
    logic  g_we;
    addr_t g_waddr;
    word_t g_wdata;
    logic  a_we;
    addr_t a_waddr;
    word_t a_wdata;
  } store_req_t;

  typedef struct packed {
    word_t g_rdata;
    word_t a_rdata_first;
    word_t a_rdata_second;
  } store_rsp_t;

  function automatic addr_t to_addr(input idx_t idx);
    return ADDR_W'(idx);
  endfunction

  function automatic logic in_range(input idx_t idx);
    return 32'(idx) < 32'(NUM_POINTS);
  endfunction

  function automatic logic fits_word(input acc_t v);
    return (&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]);
  endfunction

  function automatic word_t sat_word(input acc_t v);
    word_t r;
    if (fits_word(v)) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

  // Q32.32 product to Q16.16, round half up
  function automatic acc_t round_q16(input dec_t p);
    dec_t t;
    t = p + 64'sd32768;
    return ACC_W'(t >>> 16);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/svmgu_store.sv
// Gradient and alpha memories: synchronous, registered read.
`default_nettype none

module svmgu_store (
  input  wire                     clk_i,
  input  wire svmgu_pkg::store_req_t req_i,
  output svmgu_pkg::store_rsp_t   rsp_o
);
  import svmgu_pkg::*;

  word_t g_mem [NUM_POINTS];
  word_t a_mem [NUM_POINTS];

  word_t g_rdata_q;
  word_t a_rdata_first_q;
  word_t a_rdata_second_q;

  always_ff @(posedge clk_i) begin
    if (req_i.g_we) begin
      g_mem[req_i.g_waddr] <= req_i.g_wdata;
    end
    if (req_i.rd_en) begin
      g_rdata_q <= g_mem[req_i.g_raddr];
    end
  end

  // alpha store: one write port, two read ports for the pair indices
  always_ff @(posedge clk_i) begin
    if (req_i.a_we) begin
      a_mem[req_i.a_waddr] <= req_i.a_wdata;
    end
    if (req_i.rd_en) begin
      a_rdata_first_q  <= a_mem[req_i.a_raddr_first];
      a_rdata_second_q <= a_mem[req_i.a_raddr_second];
    end
  end

  assign rsp_o.g_rdata        = g_rdata_q;
  assign rsp_o.a_rdata_first  = a_rdata_first_q;
  assign rsp_o.a_rdata_second = a_rdata_second_q;

endmodule

`default_nettype wire

FILE: rtl/svm_gradient_store_update.sv
// Gradient and alpha store update for an SMO one-class SVM solver.
//
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// load alpha, accumulate alpha*Q into a gradient entry, pair update of one
// gradient column, or query of one entry against rho1/rho2. Each transfer
// gives exactly one result on the output channel (out_valid_o / out_stall_i).
// One item is worked on at a time; all but load alpha go through the shared
// 33x33 multiplier, and all but query write the stores. States from transfer
// to result: load alpha PREP, DONE; accumulate PREP, MUL, ACC, DONE; query
// PREP, MUL, QRES, DONE; pair update PREP, MUL, ACC, MUL, ACC, DONE, with
// ALPHA_B before DONE on the last column (second alpha write).
// The result sits in an output register, so the next item is taken while an
// earlier result is still stalled; the block only waits at its final step if
// that register is still full.
// After reset both stores are cleared to zero, one entry per cycle: the block
// holds in_stall_o high until all NUM_POINTS entries are cleared, before the first transfer.
`default_nettype none

module svm_gradient_store_update (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [1:0]               op_i,
  input  wire  [9:0]               first_index_i,
  input  wire  [9:0]               second_index_i,
  input  wire  [9:0]               col_index_i,
  input  wire  signed [31:0]       alpha_first_i,
  input  wire  signed [31:0]       alpha_second_i,
  input  wire  signed [31:0]       q_first_i,
  input  wire  signed [31:0]       q_second_i,
  input  wire                      last_column_i,
  input  wire  signed [31:0]       rho_low_i,
  input  wire  signed [31:0]       rho_high_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output svmgu_pkg::word_t         gradient_value_o,
  output svmgu_pkg::word_t         objective_o,
  output svmgu_pkg::dec_t          decision_o,
  output logic                     saturated_o
);
  import svmgu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ACC,
    S_ALPHA_B,
    S_QRES,
    S_DONE
  } state_e;

  state_e state_q;
  addr_t  clr_q;

  op_e   op_q;
  idx_t  ia_q, ib_q, ic_q;
  word_t a1_q, a2_q, q1_q, q2_q, r1_q, r2_q;
  logic  last_q;

  logic signed [MUL_W-1:0] mul_a_q, mul_b_q;
  logic signed [2*MUL_W-1:0] mul_full;
  dec_t  prod_q;
  acc_t  acc_q;
  word_t delta_a_q;
  logic  second_q;
  logic  neg_q;

  word_t res_g_q, res_obj_q;
  dec_t  res_dec_q;
  logic  sat_q;

  logic  out_valid_q;
  word_t out_g_q, out_obj_q;
  dec_t  out_dec_q;
  logic  out_sat_q;

  store_req_t req;
  store_rsp_t rsp;
  logic       in_fire;

  // operands seen at the prepare step, plus the accumulate sum and the decision
  idx_t  gidx;
  word_t g_rd, al_f, al_s;
  logic signed [DATA_W:0] db_w, da_w, d1_w, d2_w, dmin_w, abs1, abs2;
  word_t dbs, das;
  acc_t  sum_w;
  dec_t  dec_w;
  logic  dec_sat;
  logic [DEC_W-1:0] mag;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  svmgu_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign mul_full = mul_a_q * mul_b_q;

  always_comb begin
    gidx   = ((op_q == OP_ACCUM) || (op_q == OP_PAIR)) ? ic_q : ia_q;
    g_rd   = in_range(gidx) ? rsp.g_rdata : '0;
    al_f   = in_range(ia_q) ? rsp.a_rdata_first : '0;
    al_s   = in_range(ib_q) ? rsp.a_rdata_second : '0;
    db_w   = (DATA_W+1)'(a2_q) - (DATA_W+1)'(al_s);
    da_w   = (DATA_W+1)'(a1_q) - (DATA_W+1)'(al_f);
    dbs    = sat_word(ACC_W'(db_w));
    das    = sat_word(ACC_W'(da_w));
    d1_w   = (DATA_W+1)'(g_rd) - (DATA_W+1)'(r1_q);
    d2_w   = (DATA_W+1)'(r2_q) - (DATA_W+1)'(g_rd);
    dmin_w = (d1_w < d2_w) ? d1_w : d2_w;
    abs1   = d1_w[DATA_W] ? -d1_w : d1_w;
    abs2   = d2_w[DATA_W] ? -d2_w : d2_w;
    sum_w  = acc_q + round_q16(prod_q);
    // decision: product of magnitudes with the sign put back, clipped
    mag    = prod_q;
    if (neg_q) begin
      if (mag[DEC_W-1]) begin
        dec_w   = DEC_MIN;
        dec_sat = |mag[DEC_W-2:0];
      end else begin
        dec_w   = -$signed(mag);
        dec_sat = 1'b0;
      end
    end else begin
      if (mag[DEC_W-1]) begin
        dec_w   = DEC_MAX;
        dec_sat = 1'b1;
      end else begin
        dec_w   = $signed(mag);
        dec_sat = 1'b0;
      end
    end
  end

  always_comb begin
    req                = '0;
    req.rd_en          = in_fire;
    req.g_raddr        = to_addr(((op_e'(op_i) == OP_ACCUM) || (op_e'(op_i) == OP_PAIR))
                                 ? col_index_i : first_index_i);
    req.a_raddr_first  = to_addr(first_index_i);
    req.a_raddr_second = to_addr(second_index_i);
    case (state_q)
      S_CLEAR: begin
        req.g_we    = 1'b1;
        req.g_waddr = clr_q;
        req.a_we    = 1'b1;
        req.a_waddr = clr_q;
      end
      S_PREP: begin
        req.a_we    = (op_q == OP_LOAD_ALPHA) && in_range(ia_q);
        req.a_waddr = to_addr(ia_q);
        req.a_wdata = a1_q;
      end
      S_ACC: begin
        req.g_we    = second_q && in_range(ic_q);
        req.g_waddr = to_addr(ic_q);
        req.g_wdata = sat_word(sum_w);
        // alpha a first; alpha b follows and wins on equal indices
        req.a_we    = second_q && (op_q == OP_PAIR) && last_q && in_range(ia_q);
        req.a_waddr = to_addr(ia_q);
        req.a_wdata = a1_q;
      end
      S_ALPHA_B: begin
        req.a_we    = in_range(ib_q);
        req.a_waddr = to_addr(ib_q);
        req.a_wdata = a2_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      op_q        <= OP_LOAD_ALPHA;
      ia_q        <= '0;
      ib_q        <= '0;
      ic_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      q1_q        <= '0;
      q2_q        <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      last_q      <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      delta_a_q   <= '0;
      second_q    <= 1'b0;
      neg_q       <= 1'b0;
      res_g_q     <= '0;
      res_obj_q   <= '0;
      res_dec_q   <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_g_q     <= '0;
      out_obj_q   <= '0;
      out_dec_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(NUM_POINTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_q    <= op_e'(op_i);
            ia_q    <= first_index_i;
            ib_q    <= second_index_i;
            ic_q    <= col_index_i;
            a1_q    <= alpha_first_i;
            a2_q    <= alpha_second_i;
            q1_q    <= q_first_i;
            q2_q    <= q_second_i;
            r1_q    <= rho_low_i;
            r2_q    <= rho_high_i;
            last_q  <= last_column_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          res_obj_q <= '0;
          res_dec_q <= '0;
          sat_q     <= 1'b0;
          acc_q     <= ACC_W'(g_rd);
          case (op_q)
            OP_LOAD_ALPHA: begin
              res_g_q <= g_rd;
              state_q <= S_DONE;
            end
            OP_ACCUM: begin
              mul_a_q  <= MUL_W'(al_f);
              mul_b_q  <= MUL_W'(q1_q);
              second_q <= 1'b1;
              state_q  <= S_MUL;
            end
            OP_PAIR: begin
              mul_a_q   <= MUL_W'(q2_q);
              mul_b_q   <= MUL_W'(dbs);
              delta_a_q <= das;
              sat_q     <= !fits_word(ACC_W'(db_w)) || !fits_word(ACC_W'(da_w));
              second_q  <= 1'b0;
              state_q   <= S_MUL;
            end
            default: begin
              // query
              res_g_q   <= g_rd;
              res_obj_q <= sat_word(ACC_W'(dmin_w));
              sat_q     <= !fits_word(ACC_W'(dmin_w));
              mul_a_q   <= {1'b0, abs1[DATA_W-1:0]};
              mul_b_q   <= {1'b0, abs2[DATA_W-1:0]};
              neg_q     <= d1_w[DATA_W] ^ d2_w[DATA_W];
              state_q   <= S_MUL;
            end
          endcase
        end
        S_MUL: begin
          prod_q  <= mul_full[DEC_W-1:0];
          state_q <= (op_q == OP_QUERY) ? S_QRES : S_ACC;
        end
        S_ACC: begin
          if (!second_q) begin
            acc_q    <= sum_w;
            mul_a_q  <= MUL_W'(q1_q);
            mul_b_q  <= MUL_W'(delta_a_q);
            second_q <= 1'b1;
            state_q  <= S_MUL;
          end else begin
            res_g_q <= sat_word(sum_w);
            sat_q   <= sat_q || !fits_word(sum_w);
            state_q <= ((op_q == OP_PAIR) && last_q) ? S_ALPHA_B : S_DONE;
          end
        end
        S_ALPHA_B: begin
          state_q <= S_DONE;
        end
        S_QRES: begin
          res_dec_q <= dec_w;
          sat_q     <= sat_q || dec_sat;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_g_q     <= res_g_q;
            out_obj_q   <= res_obj_q;
            out_dec_q   <= res_dec_q;
            out_sat_q   <= sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gradient_value_o = out_g_q;
  assign objective_o      = out_obj_q;
  assign decision_o       = out_dec_q;
  assign saturated_o      = out_sat_q;

  // no store write while waiting for a transfer
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(req.g_we || req.a_we))
    else $error("store written while idle");

  // a new result is only ever loaded from the final step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the final step");

  // gradient entries change only during clearing or the last accumulate step
  a_grad_write_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.g_we |-> ((state_q == S_CLEAR) || ((state_q == S_ACC) && second_q)))
    else $error("unexpected gradient write");

endmodule

`default_nettype wire

FILE: tb/svm_gradient_store_update_checker.sv
// Checker for the SVM gradient store: predicts each result and compares it.
`timescale 1ns / 1ps

module svm_gradient_store_update_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire  [1:0]        op_i,
  input  wire  [9:0]        first_index_i,
  input  wire  [9:0]        second_index_i,
  input  wire  [9:0]        col_index_i,
  input  wire  signed [31:0] alpha_first_i,
  input  wire  signed [31:0] alpha_second_i,
  input  wire  signed [31:0] q_first_i,
  input  wire  signed [31:0] q_second_i,
  input  wire               last_column_i,
  input  wire  signed [31:0] rho_low_i,
  input  wire  signed [31:0] rho_high_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire  signed [31:0] gradient_value_i,
  input  wire  signed [31:0] objective_i,
  input  wire  signed [63:0] decision_i,
  input  wire               saturated_i,
  output int                mismatch_count_o,
  output int                results_checked_o,
  output int                outstanding_o,
  output int                clipped_count_o
);
  import svmgu_pkg::*;

  typedef struct packed {
    word_t gradient;
    word_t objective;
    dec_t  decision;
    logic  saturated;
  } step_result_t;

  word_t        grad_mem  [NUM_POINTS];
  word_t        alpha_mem [NUM_POINTS];
  step_result_t expected_q [$];
  int           mismatches;
  int           checked;
  int           clipped_seen;

  function automatic longint clip_word(input longint v, inout bit clipped);
    longint r;
    r = v;
    if (v > longint'(WORD_MAX)) begin
      clipped = 1'b1;
      r = longint'(WORD_MAX);
    end else if (v < longint'(WORD_MIN)) begin
      clipped = 1'b1;
      r = longint'(WORD_MIN);
    end
    return r;
  endfunction

  // Q32.32 to Q16.16, half rounds towards plus infinity
  function automatic longint round_half_up(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  // Updates the shadow stores and returns the result one operation gives.
  function automatic step_result_t apply_operation(
    input op_e   op,
    input idx_t  ia,
    input idx_t  ib,
    input idx_t  ic,
    input word_t a1,
    input word_t a2,
    input word_t q1,
    input word_t q2,
    input logic  last,
    input word_t r1,
    input word_t r2
  );
    step_result_t        r;
    bit                  clipped;
    longint              sum;
    longint              delta_a;
    longint              delta_b;
    longint              d1;
    longint              d2;
    logic signed [127:0] prod;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    r = '0;
    clipped = 1'b0;
    case (op)
      OP_LOAD_ALPHA: begin
        alpha_mem[ia] = a1;
        r.gradient = grad_mem[ia];
      end
      OP_ACCUM: begin
        sum = longint'(grad_mem[ic])
            + round_half_up(longint'(alpha_mem[ia]) * longint'(q1));
        r.gradient = word_t'(clip_word(sum, clipped));
        grad_mem[ic] = r.gradient;
      end
      OP_PAIR: begin
        // deltas come from the stored alphas, never from this column's write
        delta_b = clip_word(longint'(a2) - longint'(alpha_mem[ib]), clipped);
        delta_a = clip_word(longint'(a1) - longint'(alpha_mem[ia]), clipped);
        sum = longint'(grad_mem[ic]) + round_half_up(longint'(q2) * delta_b)
            + round_half_up(longint'(q1) * delta_a);
        r.gradient = word_t'(clip_word(sum, clipped));
        grad_mem[ic] = r.gradient;
        if (last) begin
          alpha_mem[ia] = a1;
          alpha_mem[ib] = a2;
        end
      end
      default: begin
        r.gradient = grad_mem[ia];
        d1 = longint'(r.gradient) - longint'(r1);
        d2 = longint'(r2) - longint'(r.gradient);
        r.objective = word_t'(clip_word((d1 < d2) ? d1 : d2, clipped));
        prod = d1;
        prod = prod * d2;
        hi_lim = DEC_MAX;
        lo_lim = DEC_MIN;
        if (prod > hi_lim) begin
          clipped = 1'b1;
          r.decision = DEC_MAX;
        end else if (prod < lo_lim) begin
          clipped = 1'b1;
          r.decision = DEC_MIN;
        end else begin
          r.decision = dec_t'(prod);
        end
      end
    endcase
    r.saturated = clipped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    step_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        grad_mem[i] = '0;
        alpha_mem[i] = '0;
      end
      expected_q.delete();
      mismatches = 0;
      checked = 0;
      clipped_seen = 0;
    end else begin
      // results first: an item taken at this edge cannot answer at it
      if (out_valid_i && !out_stall_i) begin
        got = {gradient_value_i, objective_i, decision_i, saturated_i};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing pending: G=%0d obj=%0d dec=%0d sat=%0b",
                     $realtime, got.gradient, got.objective, got.decision, got.saturated);
          end
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.saturated) clipped_seen++;
          if (got.gradient !== want.gradient || got.objective !== want.objective ||
              got.decision !== want.decision || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d differs: expected G=%0d obj=%0d dec=%0d sat=%0b",
                       $realtime, checked, want.gradient, want.objective,
                       want.decision, want.saturated);
              $display("    got G=%0d obj=%0d dec=%0d sat=%0b",
                       got.gradient, got.objective, got.decision, got.saturated);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_operation(op_e'(op_i), first_index_i, second_index_i,
                                             col_index_i, alpha_first_i, alpha_second_i,
                                             q_first_i, q_second_i, last_column_i,
                                             rho_low_i, rho_high_i));
      end
    end
    mismatch_count_o <= mismatches;
    results_checked_o <= checked;
    outstanding_o <= expected_q.size();
    clipped_count_o <= clipped_seen;
  end

endmodule

FILE: tb/svm_gradient_store_update_tb.sv
// Top of the SVM gradient store testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps

module svm_gradient_store_update_tb;
  import svmgu_pkg::*;

  localparam int ITEMS_TOTAL    = 1050;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    op_e   op;
    idx_t  first_index;
    idx_t  second_index;
    idx_t  col_index;
    word_t alpha_first;
    word_t alpha_second;
    word_t q_first;
    word_t q_second;
    logic  last_column;
    word_t rho_low;
    word_t rho_high;
  } solver_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  solver_cmd_t drv = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  word_t       gradient_value_o;
  word_t       objective_o;
  dec_t        decision_o;
  logic        saturated_o;

  int mismatch_count;
  int results_checked;
  int outstanding;
  int clipped_count;
  int items_sent = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  int stall_hold = 0;
  bit calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  svm_gradient_store_update DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .op_i            (drv.op),
    .first_index_i   (drv.first_index),
    .second_index_i  (drv.second_index),
    .col_index_i     (drv.col_index),
    .alpha_first_i   (drv.alpha_first),
    .alpha_second_i  (drv.alpha_second),
    .q_first_i       (drv.q_first),
    .q_second_i      (drv.q_second),
    .last_column_i   (drv.last_column),
    .rho_low_i       (drv.rho_low),
    .rho_high_i      (drv.rho_high),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .gradient_value_o(gradient_value_o),
    .objective_o     (objective_o),
    .decision_o      (decision_o),
    .saturated_o     (saturated_o)
  );

  svm_gradient_store_update_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall_o),
    .op_i             (drv.op),
    .first_index_i    (drv.first_index),
    .second_index_i   (drv.second_index),
    .col_index_i      (drv.col_index),
    .alpha_first_i    (drv.alpha_first),
    .alpha_second_i   (drv.alpha_second),
    .q_first_i        (drv.q_first),
    .q_second_i       (drv.q_second),
    .last_column_i    (drv.last_column),
    .rho_low_i        (drv.rho_low),
    .rho_high_i       (drv.rho_high),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall),
    .gradient_value_i (gradient_value_o),
    .objective_i      (objective_o),
    .decision_i       (decision_o),
    .saturated_i      (saturated_o),
    .mismatch_count_o (mismatch_count),
    .results_checked_o(results_checked),
    .outstanding_o    (outstanding),
    .clipped_count_o  (clipped_count)
  );

  // result side back-pressure: mostly short bursts, now and then a long hold
  always @(posedge clk_i) begin
    int r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 8);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // few live indices so that entries are revisited, plus the top of the range and any index now and then
  function automatic idx_t pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return idx_t'($urandom_range(0, 15));
    if (r == 7) return idx_t'(1023 - $urandom_range(0, 3));
    return idx_t'($urandom);
  endfunction

  function automatic word_t pick_value();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: v = WORD_MIN;
        1: v = WORD_MAX;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else if (r < 3) begin
      v = $urandom;
    end else begin
      // within about +/-4.0 in Q16.16
      v = int'($urandom_range(0, 524288)) - 262144;
    end
    return word_t'(v);
  endfunction

  task automatic send_cmd(input solver_cmd_t cmd);
    int gap;
    drv <= cmd;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    op_count[cmd.op]++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input idx_t idx, input word_t alpha);
    solver_cmd_t c;
    c = '0;
    c.op = OP_LOAD_ALPHA;
    c.first_index = idx;
    c.alpha_first = alpha;
    send_cmd(c);
  endtask

  task automatic send_accum(input idx_t row, input idx_t col, input word_t q);
    solver_cmd_t c;
    c = '0;
    c.op = OP_ACCUM;
    c.first_index = row;
    c.col_index = col;
    c.q_first = q;
    send_cmd(c);
  endtask

  task automatic send_query(input idx_t idx, input word_t rho1, input word_t rho2);
    solver_cmd_t c;
    c = '0;
    c.op = OP_QUERY;
    c.first_index = idx;
    c.rho_low = rho1;
    c.rho_high = rho2;
    send_cmd(c);
  endtask

  task automatic send_pair(input idx_t ia, input idx_t ib, input idx_t col,
                           input word_t a1, input word_t a2,
                           input word_t q1, input word_t q2, input logic last);
    solver_cmd_t c;
    c = '0;
    c.op = OP_PAIR;
    c.first_index = ia;
    c.second_index = ib;
    c.col_index = col;
    c.alpha_first = a1;
    c.alpha_second = a2;
    c.q_first = q1;
    c.q_second = q2;
    c.last_column = last;
    send_cmd(c);
  endtask

  initial begin
    solver_cmd_t c;
    idx_t        ia;
    idx_t        ib;
    word_t       a1;
    word_t       a2;
    int          kind;
    int          n;
    bit          drop_last;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, rounding ties, clipping and the pair update corners
    send_query(10'd0, WORD_MIN, WORD_MAX);
    send_query(10'd1023, WORD_MAX, WORD_MIN);
    send_load(10'd1023, WORD_MAX);
    send_load(10'd0, WORD_MIN);
    send_load(10'd3, 32'sd1);
    send_accum(10'd1023, 10'd7, WORD_MAX);
    send_accum(10'd0, 10'd8, WORD_MAX);
    send_accum(10'd3, 10'd9, 32'sh0000_8000);
    send_accum(10'd3, 10'd9, -32'sh0000_8000);
    send_accum(10'd3, 10'd9, -32'sh0000_8001);
    send_query(10'd7, WORD_MIN, WORD_MIN);
    send_query(10'd8, WORD_MAX, WORD_MAX);
    send_query(10'd7, WORD_MIN, WORD_MAX);
    send_pair(10'd1023, 10'd0, 10'd1023, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
    send_pair(10'd1023, 10'd0, 10'd0, WORD_MIN, WORD_MAX, WORD_MIN, 32'sh0001_0000,
              1'b1);
    // same index twice: the second alpha is the one kept
    send_pair(10'd5, 10'd5, 10'd10, 32'sh0002_0000, 32'sh0003_0000,
              32'sh0001_0000, 32'sh0001_0000, 1'b1);
    send_accum(10'd5, 10'd11, 32'sh0001_0000);
    send_accum(10'd1023, 10'd1023, -32'sd1);
    send_query(10'd1023, -32'sh0001_0000, 32'sh0002_0000);
    send_load(10'd1023, -32'sd1);
    send_query(10'd9, 32'sd0, 32'sd0);
    send_pair(10'd1023, 10'd1023, 10'd1023, 32'sd0, 32'sd0, -32'sd1, -32'sd1, 1'b1);

    // random: mostly well-formed solver phases, some abandoned sweeps and noise
    while (items_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        n = $urandom_range(1, 4);
        repeat (n) send_load(pick_index(), pick_value());
      end else if (kind < 8) begin
        ia = pick_index();
        n = $urandom_range(1, 6);
        repeat (n) send_accum(ia, pick_index(), pick_value());
      end else if (kind < 14) begin
        ia = pick_index();
        ib = pick_index();
        a1 = pick_value();
        a2 = pick_value();
        n = $urandom_range(1, 6);
        drop_last = ($urandom_range(0, 7) == 0);
        for (int col = 0; col < n; col++) begin
          send_pair(ia, ib, pick_index(), a1, a2, pick_value(), pick_value(),
                    !drop_last && col == n - 1);
        end
      end else if (kind < 18) begin
        n = $urandom_range(1, 4);
        repeat (n) send_query(pick_index(), pick_value(), pick_value());
      end else begin
        c = '0;
        c.op = op_e'($urandom_range(0, 3));
        c.first_index = idx_t'($urandom);
        c.second_index = idx_t'($urandom);
        c.col_index = idx_t'($urandom);
        c.alpha_first = $urandom;
        c.alpha_second = $urandom;
        c.q_first = $urandom;
        c.q_second = $urandom;
        c.last_column = 1'($urandom_range(0, 1));
        c.rho_low = $urandom;
        c.rho_high = $urandom;
        send_cmd(c);
      end
    end
    in_valid <= 1'b0;
    // the pending count is a registered copy of the checker's queue size
    @(posedge clk_i);

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transfers: %0d alpha loads, %0d accumulates, %0d pair columns,",
             items_sent, op_count[OP_LOAD_ALPHA], op_count[OP_ACCUM], op_count[OP_PAIR]);
    $display("  %0d queries; %0d results checked, %0d of them clipped, %0d mismatches",
             op_count[OP_QUERY], results_checked, clipped_count, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
